/* design/styled_text_code_decoder_assert.svh */
// assertion helpers shared by the decoder modules
// every use is clocked on i_clk and muted while i_rst_n is low
`ifndef STYLED_TEXT_CODE_DECODER_ASSERT_SVH
`define STYLED_TEXT_CODE_DECODER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define STCD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("stcd assertion failed");

// condition must never be seen at a clock edge out of reset
`define STCD_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("stcd forbidden condition seen");

`endif

/* design/stcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stcd_pkg;

    // counter widths
    localparam int LINE_BITS = 16;
    localparam int COL_BITS  = 16;
    localparam int OUT_BITS  = 16;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    // byte codes
    localparam logic [7:0] B_TAB        = 8'h09;
    localparam logic [7:0] B_LF         = 8'h0A;
    localparam logic [7:0] B_VT         = 8'h0B;
    localparam logic [7:0] B_FF         = 8'h0C;
    localparam logic [7:0] B_CR         = 8'h0D;
    localparam logic [7:0] B_SPACE      = 8'h20;
    localparam logic [7:0] B_TILDE      = 8'h7E;
    localparam logic [7:0] B_DASH       = 8'h2D;
    localparam logic [7:0] B_JUST_A     = 8'h81;
    localparam logic [7:0] B_ALIGN_LEFT = 8'h82;
    localparam logic [7:0] B_JUST_B     = 8'h86;
    localparam logic [7:0] B_UNDER_ON   = 8'h94;
    localparam logic [7:0] B_UNDER_OFF  = 8'h95;
    localparam logic [7:0] B_BOLD_OFF   = 8'h9C;
    localparam logic [7:0] B_BOLD_ON    = 8'h9D;
    localparam logic [7:0] B_HARD_SPACE = 8'hA0;
    localparam logic [7:0] B_HYPHEN_A   = 8'hA9;
    localparam logic [7:0] B_HYPHEN_B   = 8'hAA;
    localparam logic [7:0] B_HYPHEN_C   = 8'hAB;
    localparam logic [7:0] B_SOFT_HYP_A = 8'hAD;
    localparam logic [7:0] B_SOFT_HYP_B = 8'hAE;
    localparam logic [7:0] B_ITAL_ON    = 8'hB2;
    localparam logic [7:0] B_ITAL_OFF   = 8'hB3;
    localparam logic [7:0] B_CENTER     = 8'hC3;
    localparam logic [7:0] B_RIGHT      = 8'hC4;
    localparam logic [7:0] B_EXT_GATE   = 8'hE1;

    // gate lengths after the opening byte
    localparam logic [5:0] ALIGN_GATE_LEFT = 6'd4;
    localparam logic [5:0] EXT_GATE_LEFT   = 6'd2;

    // style bits
    localparam logic [2:0] STY_BOLD  = 3'b001;
    localparam logic [2:0] STY_ITAL  = 3'b010;
    localparam logic [2:0] STY_UNDER = 3'b100;

    // alignment codes
    localparam logic [1:0] AL_LEFT    = 2'd0;
    localparam logic [1:0] AL_CENTER  = 2'd1;
    localparam logic [1:0] AL_RIGHT   = 2'd2;
    localparam logic [1:0] AL_JUSTIFY = 2'd3;

    // break kinds
    localparam logic [1:0] BRK_PARA = 2'd0;
    localparam logic [1:0] BRK_SOFT = 2'd1;
    localparam logic [1:0] BRK_HYPH = 2'd2;
    localparam logic [1:0] BRK_EOD  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_CENTER_TRUNC = 3'd0;
    localparam logic [2:0] ERR_RIGHT_TRUNC  = 3'd2;
    localparam logic [2:0] ERR_EXT_TRUNC    = 3'd4;
    localparam logic [2:0] ERR_SKIP_TRUNC   = 3'd6;
    localparam logic [2:0] ERR_UNSUPPORTED  = 3'd7;

    // total length of codes 0xC0..0xFF: 0 variable, 1 single byte, n fixed
    localparam logic [5:0] CODE_LEN [64] = '{
        6'd6, 6'd4, 6'd3, 6'd5, 6'd5, 6'd6, 6'd4, 6'd6,
        6'd8, 6'd42, 6'd3, 6'd6, 6'd4, 6'd3, 6'd4, 6'd3,
        6'd6, 6'd0, 6'd0, 6'd4, 6'd4, 6'd4, 6'd6, 6'd0,
        6'd4, 6'd4, 6'd4, 6'd4, 6'd0, 6'd1, 6'd1, 6'd1,
        6'd1, 6'd0, 6'd0, 6'd4, 6'd0, 6'd0, 6'd0, 6'd6,
        6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1,
        6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
        6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1};

    typedef enum logic [1:0] {
        EV_CHAR  = 2'd0,
        EV_LINE  = 2'd1,
        EV_RUN   = 2'd2,
        EV_ERROR = 2'd3
    } t_event;

    typedef struct packed {
        t_event              event_res;
        logic [7:0]          char_code;
        logic                extended;
        logic [OUT_BITS-1:0] line_index;
        logic [OUT_BITS-1:0] column;
        logic [OUT_BITS-1:0] run_end;
        logic [2:0]          style;
        logic [1:0]          align;
        logic [1:0]          break_kind;
        logic [2:0]          error_code;
        logic                last;
    } t_result;

    // up to two results written into the queue by one byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_result blank_result();
        t_result r;
        r = '0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/stcd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "styled_text_code_decoder_assert.svh"

module stcd_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic          i_end_doc,
    input  wire logic [7:0]    i_byte,
    output stcd_pkg::t_push    o_push
);
    import stcd_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SKIP_FIXED,
        MODE_SKIP_GATE,
        MODE_GATE
    } t_mode;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};

    t_mode                r_mode, n_mode;
    logic [5:0]           r_left, n_left;
    logic [7:0]           r_gate, n_gate;
    logic [7:0]           r_held, n_held;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [COL_BITS-1:0]  r_col, n_col;
    logic [COL_BITS-1:0]  r_open_col, n_open_col;
    logic [2:0]           r_run_style, n_run_style;
    logic [2:0]           r_style, n_style;
    logic [1:0]           r_align, n_align;
    logic                 r_halted, n_halted;

    logic                 run_v;
    logic                 main_v;
    t_result              run_res;
    t_result              main_res;
    logic                 flush_ok;
    logic [5:0]           left_dec;
    logic [5:0]           len;
    logic [2:0]           gate_err;
    logic [OUT_BITS-1:0]  line_out;
    logic [OUT_BITS-1:0]  col_out;
    logic [LINE_BITS-1:0] line_inc;
    logic [COL_BITS-1:0]  col_inc;

    // shared pieces of the decode
    assign line_out = OUT_BITS'(r_line);
    assign col_out  = OUT_BITS'(r_col);
    assign line_inc = (r_line == LINE_MAX) ? r_line : r_line + 1'b1;
    assign col_inc  = (r_col == COL_MAX) ? r_col : r_col + 1'b1;
    assign flush_ok = (r_col > r_open_col) && (r_run_style != 3'd0);
    assign left_dec = (r_left != 6'd0) ? r_left - 6'd1 : r_left;
    assign len      = CODE_LEN[i_byte[5:0]];
    assign gate_err = (r_gate == B_CENTER) ? ERR_CENTER_TRUNC :
                      (r_gate == B_RIGHT)  ? ERR_RIGHT_TRUNC  : ERR_EXT_TRUNC;

    // open run report, built from the state before this byte
    always_comb begin
        run_res            = blank_result();
        run_res.event_res  = EV_RUN;
        run_res.line_index = line_out;
        run_res.column     = OUT_BITS'(r_open_col);
        run_res.run_end    = col_out;
        run_res.style      = r_run_style;
    end

    // byte decode and next state
    always_comb begin
        n_mode      = r_mode;
        n_left      = r_left;
        n_gate      = r_gate;
        n_held      = r_held;
        n_line      = r_line;
        n_col       = r_col;
        n_open_col  = r_open_col;
        n_run_style = r_run_style;
        n_style     = r_style;
        n_align     = r_align;
        n_halted    = r_halted;
        run_v       = 1'b0;
        main_v      = 1'b0;
        main_res    = blank_result();
        main_res.line_index = line_out;

        if (i_take && !r_halted) begin
            if (i_end_doc) begin
                if (r_mode == MODE_SKIP_FIXED || r_mode == MODE_SKIP_GATE) begin
                    main_v              = 1'b1;
                    main_res.event_res  = EV_ERROR;
                    main_res.column     = col_out;
                    main_res.error_code = ERR_SKIP_TRUNC;
                    n_halted            = 1'b1;
                end else if (r_mode == MODE_GATE) begin
                    main_v              = 1'b1;
                    main_res.event_res  = EV_ERROR;
                    main_res.column     = col_out;
                    main_res.error_code = gate_err;
                    n_halted            = 1'b1;
                end else begin
                    // close the run, report the last line, back to reset state
                    run_v               = flush_ok;
                    main_v              = 1'b1;
                    main_res.event_res  = EV_LINE;
                    main_res.align      = r_align;
                    main_res.break_kind = BRK_EOD;
                    n_mode      = MODE_IDLE;
                    n_left      = 6'd0;
                    n_gate      = 8'd0;
                    n_held      = 8'd0;
                    n_line      = '0;
                    n_col       = '0;
                    n_open_col  = '0;
                    n_run_style = 3'd0;
                    n_style     = 3'd0;
                    n_align     = AL_LEFT;
                end
            end else begin
                unique case (r_mode)
                    MODE_SKIP_FIXED: begin
                        n_left = left_dec;
                        if (left_dec == 6'd0) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_SKIP_GATE: begin
                        if (i_byte == r_gate) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_GATE: begin
                        n_left = left_dec;
                        if (r_gate == B_EXT_GATE && left_dec == 6'd1) begin
                            n_held = i_byte;
                        end
                        if (left_dec == 6'd0) begin
                            n_mode = MODE_IDLE;
                            if (i_byte != r_gate) begin
                                main_v              = 1'b1;
                                main_res.event_res  = EV_ERROR;
                                main_res.column     = col_out;
                                main_res.error_code = gate_err + 3'd1;
                                n_halted            = 1'b1;
                            end else if (r_gate == B_CENTER) begin
                                n_align = AL_CENTER;
                            end else if (r_gate == B_RIGHT) begin
                                n_align = AL_RIGHT;
                            end else begin
                                main_v             = 1'b1;
                                main_res.event_res = EV_CHAR;
                                main_res.char_code = r_held;
                                main_res.extended  = 1'b1;
                                main_res.column    = col_out;
                                n_col              = col_inc;
                            end
                        end
                    end
                    MODE_IDLE: begin
                        priority if (i_byte >= B_SPACE && i_byte <= B_TILDE) begin
                            main_v             = 1'b1;
                            main_res.event_res = EV_CHAR;
                            main_res.char_code = i_byte;
                            main_res.column    = col_out;
                            n_col              = col_inc;
                        end else begin
                            unique case (i_byte)
                                B_TAB, B_HARD_SPACE, B_HYPHEN_A, B_HYPHEN_B,
                                B_HYPHEN_C: begin
                                    main_v             = 1'b1;
                                    main_res.event_res = EV_CHAR;
                                    main_res.char_code =
                                        (i_byte == B_TAB) ? B_TAB :
                                        (i_byte == B_HARD_SPACE) ? B_SPACE : B_DASH;
                                    main_res.column    = col_out;
                                    n_col              = col_inc;
                                end
                                B_LF, B_FF, B_VT, B_CR, B_SOFT_HYP_A,
                                B_SOFT_HYP_B: begin
                                    run_v               = flush_ok;
                                    main_v              = 1'b1;
                                    main_res.event_res  = EV_LINE;
                                    main_res.align      = r_align;
                                    main_res.break_kind =
                                        (i_byte == B_LF || i_byte == B_FF) ? BRK_PARA :
                                        (i_byte == B_VT || i_byte == B_CR) ? BRK_SOFT :
                                        BRK_HYPH;
                                    n_line      = line_inc;
                                    n_col       = '0;
                                    n_open_col  = '0;
                                    n_run_style = r_style;
                                    if (i_byte == B_LF || i_byte == B_FF) begin
                                        n_align = AL_LEFT;
                                    end
                                end
                                B_BOLD_ON, B_BOLD_OFF, B_ITAL_ON, B_ITAL_OFF,
                                B_UNDER_ON, B_UNDER_OFF: begin
                                    unique case (i_byte)
                                        B_BOLD_ON:   n_style = r_style | STY_BOLD;
                                        B_BOLD_OFF:  n_style = r_style & ~STY_BOLD;
                                        B_ITAL_ON:   n_style = r_style | STY_ITAL;
                                        B_ITAL_OFF:  n_style = r_style & ~STY_ITAL;
                                        B_UNDER_ON:  n_style = r_style | STY_UNDER;
                                        default:     n_style = r_style & ~STY_UNDER;
                                    endcase
                                    // a real style change closes the open run
                                    if (n_style != r_run_style) begin
                                        run_v       = flush_ok;
                                        n_open_col  = r_col;
                                        n_run_style = n_style;
                                    end
                                end
                                B_JUST_A, B_JUST_B: begin
                                    n_align = AL_JUSTIFY;
                                end
                                B_ALIGN_LEFT: begin
                                    n_align = AL_LEFT;
                                end
                                B_CENTER, B_RIGHT: begin
                                    n_mode = MODE_GATE;
                                    n_gate = i_byte;
                                    n_left = ALIGN_GATE_LEFT;
                                end
                                B_EXT_GATE: begin
                                    n_mode = MODE_GATE;
                                    n_gate = i_byte;
                                    n_left = EXT_GATE_LEFT;
                                end
                                default: begin
                                    if (i_byte[7:6] == 2'b11) begin
                                        // 0xC0..0xFF code: multi-byte ones skipped, single-byte ones ignored
                                        if (len == 6'd0) begin
                                            n_mode = MODE_SKIP_GATE;
                                            n_gate = i_byte;
                                        end else if (len > 6'd1) begin
                                            n_mode = MODE_SKIP_FIXED;
                                            n_left = len - 6'd1;
                                        end
                                    end else if (i_byte[7:6] != 2'b10) begin
                                        main_v              = 1'b1;
                                        main_res.event_res  = EV_ERROR;
                                        main_res.column     = col_out;
                                        main_res.error_code = ERR_UNSUPPORTED;
                                        n_halted            = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // order the results for the queue, mark the last one
    always_comb begin
        o_push        = '0;
        o_push.cnt    = {1'b0, run_v} + {1'b0, main_v};
        o_push.second = main_res;
        o_push.second.last = 1'b1;
        if (run_v) begin
            o_push.first      = run_res;
            o_push.first.last = !main_v;
        end else begin
            o_push.first      = main_res;
            o_push.first.last = 1'b1;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_left      <= 6'd0;
            r_gate      <= 8'd0;
            r_held      <= 8'd0;
            r_line      <= '0;
            r_col       <= '0;
            r_open_col  <= '0;
            r_run_style <= 3'd0;
            r_style     <= 3'd0;
            r_align     <= AL_LEFT;
            r_halted    <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_left      <= n_left;
            r_gate      <= n_gate;
            r_held      <= n_held;
            r_line      <= n_line;
            r_col       <= n_col;
            r_open_col  <= n_open_col;
            r_run_style <= n_run_style;
            r_style     <= n_style;
            r_align     <= n_align;
            r_halted    <= n_halted;
        end
    end

    `STCD_ASSERT(a_halt_sticks, r_halted |=> r_halted)
    `STCD_NEVER(a_halt_silent, r_halted && o_push.cnt != 2'd0)
    `STCD_NEVER(a_two_needs_run, o_push.cnt == 2'd2 && !run_v)
    `STCD_ASSERT(a_col_saturates, (r_col == COL_MAX) |=> (r_col == COL_MAX || r_col == '0))

endmodule

`default_nettype wire

/* design/stcd_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "styled_text_code_decoder_assert.svh"

module stcd_out_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  stcd_pkg::t_push      i_push,
    output logic                 o_room,
    output logic                 o_valid,
    input  wire logic            i_pop_ready,
    output stcd_pkg::t_result    o_data
);
    import stcd_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [PTR_BITS-1:0]   wr_ptr_b;
    logic                  pop;

    // room for two more results keeps a byte from ever overrunning
    assign o_room  = r_count <= CNT_BITS'(FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_pop_ready;

    // pointer and fill bookkeeping
    assign wr_ptr_b = r_wr_ptr + PTR_BITS'(1);
    assign n_wr_ptr = r_wr_ptr + PTR_BITS'(i_push.cnt);
    assign n_rd_ptr = r_rd_ptr + PTR_BITS'(pop);
    assign n_count  = r_count + CNT_BITS'(i_push.cnt) - CNT_BITS'(pop);

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.second;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `STCD_NEVER(a_push_without_room, i_push.cnt != 2'd0 && !o_room)
    `STCD_NEVER(a_overfill, r_count > CNT_BITS'(FIFO_DEPTH))
    `STCD_ASSERT(a_pop_drains, (pop && i_push.cnt == 2'd0) |=> r_count == $past(r_count) - 1'b1)

endmodule

`default_nettype wire

/* design/styled_text_code_decoder.sv */
// Styled text code decoder: turns a word-processor document byte stream into
// character, line end, styled run and error events.
// Slave side: one transfer per document byte; i_s_tuser high marks the end of
// the document (the byte is then ignored). Master side: one transfer per
// event; o_m_tlast marks the last event caused by one input transfer.
// The events of a byte enter the queue when the byte is accepted and are
// offered on the master side once older events have left. Throughput: one byte
// per cycle while events leave one per cycle; a byte that closes a styled run
// and ends a line gives two events, so the master side may then set the pace.
// Events wait in a four-entry queue; o_s_tready drops while fewer than two
// entries are free, so a stalled receiver stalls the sender after at most
// two or three bytes that give events, and nothing is lost.
// Reset (i_rst_n low, synchronous) clears the parser state and empties the
// queue. After an error event the block swallows every byte with no event
// until reset. End of document outside a code or gate resets the parser.
`timescale 1ns / 1ps
`default_nettype none

module styled_text_code_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tuser,   // [0] action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // [7:0] char_code, [8] extended,
                                          // [24:9] line_index, [40:25] column,
                                          // [56:41] run_end, [59:57] style,
                                          // [61:60] align, [63:62] break_kind,
                                          // [66:64] error_code, [71:67] zero
    output logic [1:0]       o_m_tuser,   // [1:0] event_res
    output logic             o_m_tlast    // last
);
    import stcd_pkg::*;

    t_push   push;
    t_result res;
    logic    room;
    logic    take;

    // input transfer
    assign o_s_tready = room;
    assign take       = i_s_tvalid && room;

    stcd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_end_doc (i_s_tuser),
        .i_byte    (i_s_tdata),
        .o_push    (push)
    );

    stcd_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_data      (res)
    );

    // pack the event onto the master side
    assign o_m_tdata = {5'd0, res.error_code, res.break_kind, res.align, res.style,
                        res.run_end, res.column, res.line_index, res.extended,
                        res.char_code};
    assign o_m_tuser = res.event_res;
    assign o_m_tlast = res.last;

endmodule

`default_nettype wire

/* sim/styled_text_code_decoder_checker.sv */
`timescale 1ns / 1ps

module styled_text_code_decoder_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tuser,   // [0] action
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [71:0] i_m_tdata,   // [7:0] char_code, [8] extended,
                                          // [24:9] line_index, [40:25] column,
                                          // [56:41] run_end, [59:57] style,
                                          // [61:60] align, [63:62] break_kind,
                                          // [66:64] error_code, [71:67] zero
    input  wire logic [1:0]  i_m_tuser,   // [1:0] event_res
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending
);
    import stcd_pkg::*;

    typedef enum logic [1:0] {
        PM_IDLE,
        PM_SKIP_FIXED,
        PM_SKIP_VAR,
        PM_GATE
    } t_parse_mode;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // total length of codes 0xC0..0xFF: 0 runs up to the repeated code, 1 stands alone
    localparam logic [5:0] SKIP_LEN [64] = '{
        6'd6, 6'd4, 6'd3, 6'd5, 6'd5, 6'd6, 6'd4, 6'd6,
        6'd8, 6'd42, 6'd3, 6'd6, 6'd4, 6'd3, 6'd4, 6'd3,
        6'd6, 6'd0, 6'd0, 6'd4, 6'd4, 6'd4, 6'd6, 6'd0,
        6'd4, 6'd4, 6'd4, 6'd4, 6'd0, 6'd1, 6'd1, 6'd1,
        6'd1, 6'd0, 6'd0, 6'd4, 6'd0, 6'd0, 6'd0, 6'd6,
        6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1,
        6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
        6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1};

    // parser state as the decoder should hold it
    t_parse_mode mode;
    logic [5:0]  to_go;
    logic [7:0]  gate_byte;
    logic [7:0]  ext_byte;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [15:0] open_col;
    logic [2:0]  run_style;
    logic [2:0]  style_on;
    logic [1:0]  line_align;
    logic        halted;

    t_result step_events[$];
    t_result expected_events[$];
    int      mismatches = 0;

    task automatic clear_state();
        mode       = PM_IDLE;
        to_go      = '0;
        gate_byte  = '0;
        ext_byte   = '0;
        line_no    = '0;
        col_no     = '0;
        open_col   = '0;
        run_style  = '0;
        style_on   = '0;
        line_align = AL_LEFT;
        halted     = 1'b0;
    endtask

    task automatic add_event(input t_event ev, input logic [7:0] ch, input logic ext,
                             input logic [15:0] ln, input logic [15:0] col,
                             input logic [15:0] rend, input logic [2:0] sty,
                             input logic [1:0] al, input logic [1:0] brk,
                             input logic [2:0] err);
        t_result r;
        r            = '0;
        r.event_res  = ev;
        r.char_code  = ch;
        r.extended   = ext;
        r.line_index = ln;
        r.column     = col;
        r.run_end    = rend;
        r.style      = sty;
        r.align      = al;
        r.break_kind = brk;
        r.error_code = err;
        step_events.push_back(r);
    endtask

    task automatic emit_char(input logic [7:0] ch, input logic ext);
        add_event(EV_CHAR, ch, ext, line_no, col_no, '0, '0, '0, '0, '0);
        if (col_no != COUNT_MAX)
            col_no++;
    endtask

    // report the open run if it has width and style, then open a new one here
    task automatic close_run();
        if (col_no > open_col && run_style != '0)
            add_event(EV_RUN, '0, 1'b0, line_no, open_col, col_no, run_style,
                      '0, '0, '0);
        open_col  = col_no;
        run_style = style_on;
    endtask

    task automatic style_change();
        if (style_on != run_style)
            close_run();
    endtask

    task automatic end_line(input logic [1:0] kind);
        close_run();
        add_event(EV_LINE, '0, 1'b0, line_no, '0, '0, '0, line_align, kind, '0);
        if (line_no != COUNT_MAX)
            line_no++;
        col_no    = '0;
        open_col  = '0;
        run_style = style_on;
        if (kind == BRK_PARA)
            line_align = AL_LEFT;
    endtask

    task automatic halt_with(input logic [2:0] err);
        halted = 1'b1;
        add_event(EV_ERROR, '0, 1'b0, line_no, col_no, '0, '0, '0, '0, err);
    endtask

    function automatic logic [2:0] gate_trunc_code();
        if (gate_byte == B_CENTER)
            return ERR_CENTER_TRUNC;
        if (gate_byte == B_RIGHT)
            return ERR_RIGHT_TRUNC;
        return ERR_EXT_TRUNC;
    endfunction

    task automatic idle_byte(input logic [7:0] b);
        if (b >= B_SPACE && b <= B_TILDE) begin
            emit_char(b, 1'b0);
        end else begin
            case (b)
                B_TAB:                              emit_char(B_TAB, 1'b0);
                B_HARD_SPACE:                       emit_char(B_SPACE, 1'b0);
                B_HYPHEN_A, B_HYPHEN_B, B_HYPHEN_C: emit_char(B_DASH, 1'b0);
                B_LF, B_FF:                         end_line(BRK_PARA);
                B_VT, B_CR:                         end_line(BRK_SOFT);
                B_SOFT_HYP_A, B_SOFT_HYP_B:         end_line(BRK_HYPH);
                B_BOLD_ON: begin
                    style_on = style_on | STY_BOLD;
                    style_change();
                end
                B_BOLD_OFF: begin
                    style_on = style_on & ~STY_BOLD;
                    style_change();
                end
                B_ITAL_ON: begin
                    style_on = style_on | STY_ITAL;
                    style_change();
                end
                B_ITAL_OFF: begin
                    style_on = style_on & ~STY_ITAL;
                    style_change();
                end
                B_UNDER_ON: begin
                    style_on = style_on | STY_UNDER;
                    style_change();
                end
                B_UNDER_OFF: begin
                    style_on = style_on & ~STY_UNDER;
                    style_change();
                end
                B_JUST_A, B_JUST_B: line_align = AL_JUSTIFY;
                B_ALIGN_LEFT:       line_align = AL_LEFT;
                B_CENTER, B_RIGHT: begin
                    mode      = PM_GATE;
                    gate_byte = b;
                    to_go     = 6'd4;
                end
                B_EXT_GATE: begin
                    mode      = PM_GATE;
                    gate_byte = b;
                    to_go     = 6'd2;
                end
                default: begin
                    // 0x80..0xBF not listed above pass silently
                    if (b[7:6] == 2'b11) begin
                        if (SKIP_LEN[b[5:0]] == 6'd0) begin
                            mode      = PM_SKIP_VAR;
                            gate_byte = b;
                        end else if (SKIP_LEN[b[5:0]] > 6'd1) begin
                            mode  = PM_SKIP_FIXED;
                            to_go = SKIP_LEN[b[5:0]] - 6'd1;
                        end
                    end else if (b[7:6] != 2'b10) begin
                        halt_with(ERR_UNSUPPORTED);
                    end
                end
            endcase
        end
    endtask

    // work out the events of one accepted byte and queue them
    task automatic decode_byte(input logic eod, input logic [7:0] b);
        t_result r;
        step_events.delete();
        if (!halted) begin
            if (eod) begin
                case (mode)
                    PM_SKIP_FIXED, PM_SKIP_VAR: halt_with(ERR_SKIP_TRUNC);
                    PM_GATE:                    halt_with(gate_trunc_code());
                    default: begin
                        close_run();
                        add_event(EV_LINE, '0, 1'b0, line_no, '0, '0, '0, line_align,
                                  BRK_EOD, '0);
                        clear_state();
                    end
                endcase
            end else begin
                case (mode)
                    PM_SKIP_FIXED: begin
                        if (to_go != '0)
                            to_go--;
                        if (to_go == '0)
                            mode = PM_IDLE;
                    end
                    PM_SKIP_VAR: begin
                        if (b == gate_byte)
                            mode = PM_IDLE;
                    end
                    PM_GATE: begin
                        if (to_go != '0)
                            to_go--;
                        if (gate_byte == B_EXT_GATE && to_go == 6'd1)
                            ext_byte = b;
                        if (to_go == '0) begin
                            mode = PM_IDLE;
                            if (b != gate_byte)
                                halt_with(gate_trunc_code() + 3'd1);
                            else if (gate_byte == B_CENTER)
                                line_align = AL_CENTER;
                            else if (gate_byte == B_RIGHT)
                                line_align = AL_RIGHT;
                            else
                                emit_char(ext_byte, 1'b1);
                        end
                    end
                    default: idle_byte(b);
                endcase
            end
        end
        foreach (step_events[i]) begin
            r      = step_events[i];
            r.last = (i == step_events.size() - 1);
            expected_events.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // compare one outgoing event with the oldest one waiting
    task automatic compare_event();
        t_result want;
        if (expected_events.size() == 0) begin
            mismatches++;
            $display("%0t: event expected none got tuser %0h tdata %h tlast %b",
                     $time, i_m_tuser, i_m_tdata, i_m_tlast);
        end else begin
            want = expected_events.pop_front();
            check_field("event_res", 32'(want.event_res), 32'(i_m_tuser));
            check_field("char_code", 32'(want.char_code), 32'(i_m_tdata[7:0]));
            check_field("extended", 32'(want.extended), 32'(i_m_tdata[8]));
            check_field("line_index", 32'(want.line_index), 32'(i_m_tdata[24:9]));
            check_field("column", 32'(want.column), 32'(i_m_tdata[40:25]));
            check_field("run_end", 32'(want.run_end), 32'(i_m_tdata[56:41]));
            check_field("style", 32'(want.style), 32'(i_m_tdata[59:57]));
            check_field("align", 32'(want.align), 32'(i_m_tdata[61:60]));
            check_field("break_kind", 32'(want.break_kind), 32'(i_m_tdata[63:62]));
            check_field("error_code", 32'(want.error_code), 32'(i_m_tdata[66:64]));
            check_field("tdata padding", '0, 32'(i_m_tdata[71:67]));
            check_field("last", 32'(want.last), 32'(i_m_tlast));
        end
    endtask

    // outgoing transfers first: none of them can stem from a byte taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_events.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                compare_event();
            if (i_s_tvalid && i_s_tready)
                decode_byte(i_s_tuser, i_s_tdata);
        end
        o_pending    = expected_events.size();
        o_fail_count = mismatches;
    end

endmodule

/* sim/styled_text_code_decoder_test.sv */
`timescale 1ns / 1ps

module styled_text_code_decoder_test;
    import stcd_pkg::*;

    localparam int          OPENING_LEN   = 36;
    localparam int          RANDOM_BYTES  = 680;
    localparam int          HOLD_CYCLES   = 80;
    localparam logic [8:0]  DOC_END       = 9'h100;
    localparam logic [7:0]  VAR_SKIP_CODE = 8'hF1;

    localparam logic [7:0] TEXT_EXTRAS [5] = '{B_TAB, B_HARD_SPACE, B_HYPHEN_A,
                                               B_HYPHEN_B, B_HYPHEN_C};
    localparam logic [7:0] STYLE_CODES [6] = '{B_BOLD_ON, B_BOLD_OFF, B_ITAL_ON,
                                               B_ITAL_OFF, B_UNDER_ON, B_UNDER_OFF};
    localparam logic [7:0] BREAK_CODES [6] = '{B_LF, B_FF, B_VT, B_CR,
                                               B_SOFT_HYP_A, B_SOFT_HYP_B};
    localparam logic [7:0] ALIGN_CODES [3] = '{B_JUST_A, B_JUST_B, B_ALIGN_LEFT};

    // short document over text, style, break, alignment, gate and variable skip codes, ending inside a bold run
    localparam logic [8:0] OPENING [OPENING_LEN] = '{
        {1'b0, B_BOLD_ON}, {1'b0, B_SPACE}, {1'b0, B_TILDE}, {1'b0, B_ITAL_ON},
        {1'b0, B_TAB}, {1'b0, B_UNDER_ON}, {1'b0, B_HARD_SPACE}, {1'b0, B_HYPHEN_C},
        {1'b0, B_BOLD_OFF}, {1'b0, B_LF}, {1'b0, B_JUST_A},
        {1'b0, B_EXT_GATE}, 9'h0FF, {1'b0, B_EXT_GATE}, {1'b0, B_CR},
        {1'b0, B_CENTER}, 9'h000, 9'h07F, 9'h080, {1'b0, B_CENTER},
        {1'b0, B_SOFT_HYP_B},
        {1'b0, B_RIGHT}, 9'h01F, {1'b0, B_EXT_GATE}, {1'b0, B_CENTER}, {1'b0, B_RIGHT},
        {1'b0, B_FF}, {1'b0, B_UNDER_OFF}, {1'b0, B_ITAL_OFF},
        {1'b0, VAR_SKIP_CODE}, 9'h041, {1'b0, VAR_SKIP_CODE},
        {1'b0, B_ALIGN_LEFT}, {1'b0, B_BOLD_ON}, 9'h041, DOC_END};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] in_byte
    logic        i_s_tuser;   // [0] action
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;   // [7:0] char_code, [8] extended, [24:9] line_index,
                              // [40:25] column, [56:41] run_end, [59:57] style,
                              // [61:60] align, [63:62] break_kind,
                              // [66:64] error_code, [71:67] zero
    logic [1:0]  o_m_tuser;   // [1:0] event_res
    logic        o_m_tlast;

    int   fail_count;
    int   pending;
    int   bytes_sent  = 0;
    logic calm        = 1'b0;
    logic want_hold   = 1'b0;
    logic hold_served = 1'b0;

    always #6 i_clk = ~i_clk;

    styled_text_code_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    styled_text_code_decoder_checker watcher (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // offer one byte, maybe after a gap, and hold it until the transfer
    task automatic put_byte(input logic eod, input logic [7:0] b);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= eod;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // one well formed piece of document text
    task automatic put_piece();
        int         kind;
        logic [7:0] code;
        logic [7:0] fill;
        kind = $urandom_range(0, 31);
        if (kind < 14 || kind > 27) begin
            put_byte(1'b0, 8'($urandom_range(B_SPACE, B_TILDE)));
        end else if (kind == 14) begin
            put_byte(1'b0, TEXT_EXTRAS[$urandom_range(0, 4)]);
        end else if (kind < 19) begin
            put_byte(1'b0, STYLE_CODES[$urandom_range(0, 5)]);
        end else if (kind < 21) begin
            put_byte(1'b0, BREAK_CODES[$urandom_range(0, 5)]);
        end else if (kind == 21) begin
            put_byte(1'b0, ALIGN_CODES[$urandom_range(0, 2)]);
        end else if (kind == 22) begin
            code = $urandom_range(0, 1) ? B_CENTER : B_RIGHT;
            put_byte(1'b0, code);
            repeat (3) put_byte(1'b0, 8'($urandom_range(0, 255)));
            put_byte(1'b0, code);
        end else if (kind < 25) begin
            put_byte(1'b0, B_EXT_GATE);
            put_byte(1'b0, 8'($urandom_range(0, 255)));
            put_byte(1'b0, B_EXT_GATE);
        end else if (kind == 25) begin
            do code = 8'($urandom_range(8'hC0, 8'hFF));
            while (code == B_CENTER || code == B_RIGHT || code == B_EXT_GATE ||
                   CODE_LEN[code[5:0]] == 6'd0);
            put_byte(1'b0, code);
            repeat (CODE_LEN[code[5:0]] - 6'd1) put_byte(1'b0, 8'($urandom_range(0, 255)));
        end else if (kind == 26) begin
            do code = 8'($urandom_range(8'hC0, 8'hFF));
            while (code == B_EXT_GATE || CODE_LEN[code[5:0]] != 6'd0);
            put_byte(1'b0, code);
            repeat ($urandom_range(0, 4)) begin
                do fill = 8'($urandom_range(0, 255)); while (fill == code);
                put_byte(1'b0, fill);
            end
            put_byte(1'b0, code);
        end else begin
            put_byte(1'b0, 8'($urandom_range(8'h80, 8'hBF)));
        end
    endtask

    // receiver: random stalls, one long hold-off, none once things are calm
    initial begin : drain
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (want_hold && !hold_served) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_served = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int         sel;
        int         body;
        int         i;
        logic [7:0] code;
        logic [7:0] fill;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING[j])
            put_byte(OPENING[j][8], OPENING[j][7:0]);

        // random documents, the receiver stalls hard near the start
        want_hold = 1'b1;
        while (bytes_sent < OPENING_LEN + RANDOM_BYTES) begin
            repeat ($urandom_range(5, 60)) put_piece();
            put_byte(1'b1, 8'($urandom_range(0, 255)));
        end

        // a single error ends the decoding for good
        calm = 1'b1;
        repeat ($urandom_range(1, 5)) put_byte(1'b0, 8'($urandom_range(B_SPACE, B_TILDE)));
        sel = $urandom_range(0, 7);
        if (sel == ERR_UNSUPPORTED) begin
            do fill = 8'($urandom_range(0, 8'h7F));
            while ((fill >= B_SPACE && fill <= B_TILDE) || (fill >= B_TAB && fill <= B_CR));
            put_byte(1'b0, fill);
        end else if (sel == ERR_SKIP_TRUNC) begin
            do code = 8'($urandom_range(8'hC0, 8'hFF));
            while (code == B_CENTER || code == B_RIGHT || code == B_EXT_GATE ||
                   CODE_LEN[code[5:0]] == 6'd1);
            put_byte(1'b0, code);
            if (CODE_LEN[code[5:0]] == 6'd0) begin
                repeat ($urandom_range(0, 3)) begin
                    do fill = 8'($urandom_range(0, 255)); while (fill == code);
                    put_byte(1'b0, fill);
                end
            end else begin
                repeat ($urandom_range(0, CODE_LEN[code[5:0]] - 2))
                    put_byte(1'b0, 8'($urandom_range(0, 255)));
            end
            put_byte(1'b1, 8'($urandom_range(0, 255)));
        end else begin
            code = (sel < ERR_RIGHT_TRUNC) ? B_CENTER :
                   (sel < ERR_EXT_TRUNC) ? B_RIGHT : B_EXT_GATE;
            body = (code == B_EXT_GATE) ? 1 : 3;
            put_byte(1'b0, code);
            if (sel[0] == 1'b0) begin
                repeat ($urandom_range(0, body)) put_byte(1'b0, 8'($urandom_range(0, 255)));
                put_byte(1'b1, 8'($urandom_range(0, 255)));
            end else begin
                repeat (body) put_byte(1'b0, 8'($urandom_range(0, 255)));
                do fill = 8'($urandom_range(0, 255)); while (fill == code);
                put_byte(1'b0, fill);
            end
        end
        // swallowed while halted
        repeat (10) put_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
        i_s_tvalid <= 1'b0;

        for (i = 0; i < 5000 && pending != 0; i++)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (pending != 0)
            $display("%0t: %0d expected events never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("** styled_text_code_decoder: PASSED **");
        else
            $display("** styled_text_code_decoder: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #(2_000_000);
        $display("** styled_text_code_decoder: FAILED **");
        $finish;
    end

endmodule

/* styled_text_code_decoder.f */
+incdir+design
design/stcd_pkg.sv
design/stcd_core.sv
design/stcd_out_fifo.sv
design/styled_text_code_decoder.sv
sim/styled_text_code_decoder_checker.sv
sim/styled_text_code_decoder_test.sv
